FILE: sv/sip_pkg.sv
package sip_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int W    = COORD_WIDTH;
  localparam int DW   = W + 1;          // endpoint difference
  localparam int PW   = 2 * W;          // coordinate product
  localparam int AW   = PW + 1;         // cross determinant of one segment
  localparam int DPW  = 2 * DW;         // difference product
  localparam int DENW = DPW + 1;        // denominator
  localparam int NPW  = AW + DW;        // numerator product
  localparam int NW   = NPW + 1;        // numerator
  localparam int QB   = W + 1;          // quotient magnitude bits kept
  localparam int QW   = QB + 1;         // signed quotient
  localparam int RW   = DENW + QB;      // divider remainder width

  typedef logic [7:0][W-1:0] coords_t;

  // Item status that travels beside the divider lanes.
  typedef struct packed {
    logic    valid;
    logic    dz;
    logic    negx;
    logic    negy;
    coords_t c;
  } meta_t;

  // v inside the closed range spanned by a and b, in either order
  function automatic logic in_span(input logic signed [QW-1:0] v,
                                   input logic signed [QW-1:0] a,
                                   input logic signed [QW-1:0] b);
    logic signed [QW-1:0] lo;
    logic signed [QW-1:0] hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    return (v >= lo) && (v <= hi);
  endfunction

endpackage

FILE: sv/sip_div.sv
// Restoring unsigned divider, one quotient bit per stage, plus an overflow
// stage up front that flags quotients that need more than QB bits.
module sip_div (
  input  logic                  clk,
  input  logic                  en,
  input  logic [sip_pkg::RW-1:0] num,
  input  logic [sip_pkg::RW-1:0] den,
  output logic [sip_pkg::QB-1:0] quo,
  output logic                  ovf
);
  import sip_pkg::*;

  logic [RW-1:0] rem [QB+1];
  logic [RW-1:0] dv  [QB+1];
  logic [QB-1:0] qt  [QB+1];
  logic          ov  [QB+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num;
      dv[0]  <= den;
      qt[0]  <= '0;
      ov[0]  <= (num >= (den << QB));
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_bit
    logic [RW-1:0] trial;
    logic          take;
    always_comb begin
      trial = dv[k-1] << (QB - k);
      take  = (rem[k-1] >= trial);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= take ? (rem[k-1] - trial) : rem[k-1];
        dv[k]  <= dv[k-1];
        qt[k]  <= qt[k-1] | (take ? (QB'(1) << (QB - k)) : '0);
        ov[k]  <= ov[k-1];
      end
    end
  end

  assign quo = qt[QB];
  assign ovf = ov[QB];

endmodule

FILE: sv/segment_intersection_point.sv
// Crossing point of two 2D segments given as signed Q7.8 endpoints. One
// transfer on s_* carries both segments; one transfer on m_* returns the hit
// flag and the crossing point, which reads zero when there is no hit
// (parallel or collinear segments, or a crossing outside either segment's
// x or y range). The block takes a new item every cycle unless a stall on
// m_tready holds it. The pipeline is six arithmetic stages (differences,
// products, determinants, numerator products, numerators, magnitudes), 18
// stages of the bit-per-stage quotient lanes, and the output register. The whole pipeline
// advances whenever the output register is empty or being taken, so a stall
// on m_tready holds every stage in place.
module segment_intersection_point (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // first_start_x, first_start_y, first_end_x, first_end_y,
  // other_start_x, other_start_y, other_end_x, other_end_y (lowest first)
  input  logic [127:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // cross_x [15:0], cross_y [31:16]
  output logic [31:0]  m_tdata,
  // hit
  output logic         m_tuser
);
  import sip_pkg::*;

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // stage 1: endpoint differences
  logic                 v1;
  coords_t              c1;
  logic signed [DW-1:0] dx12_1, dy12_1, dx34_1, dy34_1;

  // stage 2: products
  logic                  v2;
  coords_t               c2;
  logic signed [DW-1:0]  dx12_2, dy12_2, dx34_2, dy34_2;
  logic signed [DPW-1:0] pd1, pd2;
  logic signed [PW-1:0]  pa1, pa2, pb1, pb2;

  // stage 3: denominator and segment determinants
  logic                   v3;
  coords_t                c3;
  logic signed [DW-1:0]   dx12_3, dy12_3, dx34_3, dy34_3;
  logic signed [DENW-1:0] den3;
  logic signed [AW-1:0]   deta, detb;

  // stage 4: numerator products
  logic                   v4;
  coords_t                c4;
  logic signed [DENW-1:0] den4;
  logic signed [NPW-1:0]  nx1, nx2, ny1, ny2;

  // stage 5: numerators
  logic                   v5;
  coords_t                c5;
  logic signed [DENW-1:0] den5;
  logic signed [NW-1:0]   nx, ny;

  // stage 6: magnitudes and quotient signs into the divider lanes
  logic          v6, dz6, negx6, negy6;
  coords_t       c6;
  logic [RW-1:0] nmx, nmy, dmag;

  logic [QB-1:0] qx, qy;
  logic          ovx, ovy;
  meta_t         meta_in;
  meta_t         meta [QB+1];

  always_ff @(posedge clk) begin
    if (en) begin
      c1     <= coords_t'(s_tdata);
      dx12_1 <= DW'($signed(s_tdata[15:0]))    - DW'($signed(s_tdata[47:32]));
      dy12_1 <= DW'($signed(s_tdata[31:16]))   - DW'($signed(s_tdata[63:48]));
      dx34_1 <= DW'($signed(s_tdata[79:64]))   - DW'($signed(s_tdata[111:96]));
      dy34_1 <= DW'($signed(s_tdata[95:80]))   - DW'($signed(s_tdata[127:112]));

      c2     <= c1;
      dx12_2 <= dx12_1; dy12_2 <= dy12_1; dx34_2 <= dx34_1; dy34_2 <= dy34_1;
      pd1    <= dx12_1 * dy34_1;
      pd2    <= dy12_1 * dx34_1;
      pa1    <= $signed(c1[0]) * $signed(c1[3]);
      pa2    <= $signed(c1[1]) * $signed(c1[2]);
      pb1    <= $signed(c1[4]) * $signed(c1[7]);
      pb2    <= $signed(c1[5]) * $signed(c1[6]);

      c3     <= c2;
      dx12_3 <= dx12_2; dy12_3 <= dy12_2; dx34_3 <= dx34_2; dy34_3 <= dy34_2;
      den3   <= DENW'(pd1) - DENW'(pd2);
      deta   <= AW'(pa1) - AW'(pa2);
      detb   <= AW'(pb1) - AW'(pb2);

      c4   <= c3;
      den4 <= den3;
      nx1  <= deta * dx34_3;
      nx2  <= dx12_3 * detb;
      ny1  <= deta * dy34_3;
      ny2  <= dy12_3 * detb;

      c5   <= c4;
      den5 <= den4;
      nx   <= NW'(nx1) - NW'(nx2);
      ny   <= NW'(ny1) - NW'(ny2);

      c6    <= c5;
      dz6   <= (den5 == '0);
      negx6 <= nx[NW-1] ^ den5[DENW-1];
      negy6 <= ny[NW-1] ^ den5[DENW-1];
      nmx   <= RW'(nx[NW-1] ? -nx : nx);
      nmy   <= RW'(ny[NW-1] ? -ny : ny);
      dmag  <= RW'(den5[DENW-1] ? -den5 : den5);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
      v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid; v2 <= v1; v3 <= v2;
      v4 <= v3; v5 <= v4; v6 <= v5;
    end
  end

  sip_div u_div_x (.clk(clk), .en(en), .num(nmx), .den(dmag), .quo(qx), .ovf(ovx));
  sip_div u_div_y (.clk(clk), .en(en), .num(nmy), .den(dmag), .quo(qy), .ovf(ovy));

  // status line matched to the divider latency
  always_comb begin
    meta_in = '{valid: v6, dz: dz6, negx: negx6, negy: negy6, c: c6};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= QB; k++) begin
        meta[k].valid <= 1'b0;
      end
    end else if (en) begin
      meta[0] <= meta_in;
      for (int k = 1; k <= QB; k++) begin
        meta[k] <= meta[k-1];
      end
    end
  end

  // final: signed quotient, bounds check, output register
  meta_t                m;
  logic signed [QW-1:0] qxs, qys;
  logic signed [QW-1:0] e [8];
  logic                 hit_next;

  always_comb begin
    m   = meta[QB];
    qxs = m.negx ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
    qys = m.negy ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
    for (int i = 0; i < 8; i++) begin
      e[i] = QW'($signed(m.c[i]));
    end
    hit_next = !m.dz && !ovx && !ovy
            && in_span(qxs, e[0], e[2]) && in_span(qxs, e[4], e[6])
            && in_span(qys, e[1], e[3]) && in_span(qys, e[5], e[7]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= m.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tuser <= hit_next;
      m_tdata <= hit_next ? {qys[W-1:0], qxs[W-1:0]} : '0;
    end
  end

  a_nohit_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("no-hit result carries a nonzero point");

  a_ovf_nohit: assert property (@(posedge clk) disable iff (rst)
    en && m.valid && (ovx || ovy || m.dz) |=> !m_tuser)
    else $error("overflowed or zero-denominator item reported a hit");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(meta[QB]) && $stable(v6))
    else $error("pipeline moved while output stalled");

endmodule
